@@ design/mpps_pkg.sv @@
package mpps_pkg;

    localparam int MAX_PROCS_DEFAULT  = 16;
    localparam int BURST_BITS_DEFAULT = 8;

    localparam int ID_W    = 4;
    localparam int PRIO_W  = 4;
    localparam int WAIT_W  = 16;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 16;
    localparam int MODE_W  = 3;
    localparam int QUANT_W = 8;
    localparam int INBURST_W = 8;

    // Policy codes.
    localparam logic [MODE_W-1:0] POL_FCFS  = 3'd0;
    localparam logic [MODE_W-1:0] POL_NPSJF = 3'd1;
    localparam logic [MODE_W-1:0] POL_PSJF  = 3'd2;
    localparam logic [MODE_W-1:0] POL_NPPRI = 3'd3;
    localparam logic [MODE_W-1:0] POL_PPRI  = 3'd4;
    localparam logic [MODE_W-1:0] POL_RR    = 3'd5;

    // Command codes.
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic arrive;       // load the input item into its slot
        logic tick_start;   // latch effective mode and validate current process
        logic rr_rotate;    // rotate expired process to the tail
        logic scan_clear;   // start a selection scan
        logic scan_step;    // examine one ready order position
        logic commit;       // apply the tick update at the chosen slot
        logic idle_tick;    // tick with no ready process
        logic order_step;   // one compaction step of the ready order
        logic finish;       // finalize a completion
    } mpps_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_scan;    // selection by policy required
        logic need_rotate;  // round robin rotation required
        logic empty;        // ready order empty
        logic scan_last;    // scan at final position
        logic will_finish;  // chosen process completes this tick
        logic order_done;   // compaction finished
    } mpps_stat_t;

endpackage

@@ design/mpps_ctrl.sv @@
module mpps_ctrl
    import mpps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    output logic       m_valid,
    input  logic       m_ready,
    output mpps_cmd_t  cmd,
    input  mpps_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_START, ST_ROTATE, ST_SCAN, ST_COMMIT, ST_COMPACT, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Input accepted only in idle with the output slot free or draining.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_command == CMD_ARRIVE) begin
                        cmd.arrive = 1'b1;
                    end else begin
                        cmd.tick_start = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (stat.empty) begin
                    cmd.idle_tick = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.need_rotate) begin
                    cmd.rr_rotate = 1'b1;
                    state_next = ST_ROTATE;
                end else if (stat.need_scan) begin
                    cmd.scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_COMMIT;
                end
            end
            ST_ROTATE: begin
                cmd.order_step = 1'b1;
                if (stat.order_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                if (stat.will_finish) begin
                    state_next = ST_COMPACT;
                end else begin
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COMPACT: begin
                cmd.order_step = 1'b1;
                if (stat.order_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                m_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ design/mpps_dp.sv @@
module mpps_dp
    import mpps_pkg::*;
#(
    parameter int MAX_PROCS  = MAX_PROCS_DEFAULT,
    parameter int BURST_BITS = BURST_BITS_DEFAULT
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [QUANT_W-1:0]   cfg_data,
    input  logic [ID_W-1:0]      s_proc_id,
    input  logic [INBURST_W-1:0] s_burst_len,
    input  logic [PRIO_W-1:0]    s_prio_level,
    input  mpps_cmd_t            cmd,
    output mpps_stat_t           stat,
    output logic [ID_W-1:0]      m_running_id,
    output logic                 m_cpu_idle,
    output logic                 m_finished,
    output logic [WAIT_W-1:0]    m_finished_wait,
    output logic [WAIT_W-1:0]    m_finished_turnaround,
    output logic [SUM_W-1:0]     m_total_wait,
    output logic [SUM_W-1:0]     m_total_turnaround,
    output logic [CNT_W-1:0]     m_done_count
);

    localparam int SLOT_W = $clog2(MAX_PROCS);
    localparam int POS_W  = $clog2(MAX_PROCS + 1);
    localparam int IDW    = (ID_W > SLOT_W) ? ID_W : SLOT_W;

    // Configuration registers.
    logic [MODE_W-1:0]  policy_reg;
    logic [QUANT_W-1:0] quantum_reg;

    // Slot storage.
    logic [MAX_PROCS-1:0]  valid_reg;
    logic [BURST_BITS-1:0] rem_reg   [MAX_PROCS];
    logic [BURST_BITS-1:0] burst_reg [MAX_PROCS];
    logic [PRIO_W-1:0]     prio_reg  [MAX_PROCS];
    logic [WAIT_W-1:0]     wait_reg  [MAX_PROCS];

    // Ready order.
    logic [SLOT_W-1:0] order_reg [MAX_PROCS];
    logic [POS_W-1:0]  count_reg;

    // Tick state.
    logic              cur_valid_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [QUANT_W-1:0] slice_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              chosen_valid_reg;
    logic [SLOT_W-1:0] chosen_reg;
    logic [POS_W-1:0]  best_pos_reg;
    logic [POS_W-1:0]  scan_pos_reg;
    logic [POS_W-1:0]  rd_reg, wr_reg;
    logic [SLOT_W-1:0] victim_reg;
    logic              rotating_reg;

    // Completion and totals.
    logic [SUM_W-1:0] sum_wait_reg, sum_turn_reg;
    logic [CNT_W-1:0] done_reg;
    logic [WAIT_W-1:0] fin_wait_reg, fin_turn_reg;
    logic              fin_reg;
    logic              idle_out_reg;
    logic [SLOT_W-1:0] run_out_reg;

    // Arrival checks.
    logic [IDW-1:0]       in_id_w;
    logic [SLOT_W-1:0]    in_slot;
    logic [BURST_BITS-1:0] in_burst;
    logic                 arrive_ok;

    assign in_id_w  = IDW'(s_proc_id);
    assign in_slot  = in_id_w[SLOT_W-1:0];
    assign in_burst = BURST_BITS'(s_burst_len);
    assign arrive_ok = ({1'b0, in_id_w} < (IDW+1)'(MAX_PROCS)) && !valid_reg[in_slot] &&
                       (in_burst != '0);

    // Scan candidate comparison.
    logic [SLOT_W-1:0] cand, best;
    logic              better;
    assign cand = order_reg[scan_pos_reg[SLOT_W-1:0]];
    assign best = order_reg[best_pos_reg[SLOT_W-1:0]];
    always_comb begin
        case (mode_reg)
            POL_NPSJF: better = burst_reg[cand] < burst_reg[best];
            POL_PSJF:  better = rem_reg[cand] < rem_reg[best];
            POL_NPPRI, POL_PPRI: better = prio_reg[cand] > prio_reg[best];
            default:   better = 1'b0;
        endcase
    end

    // Status toward the controller.
    logic [SLOT_W-1:0] sel;
    logic [QUANT_W-1:0] quant_eff;
    assign sel       = chosen_reg;
    assign quant_eff = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;

    always_comb begin
        stat.empty       = (count_reg == '0);
        stat.need_rotate = (mode_reg == POL_RR) && cur_valid_reg && (slice_reg == '0);
        stat.need_scan   = (mode_reg != POL_RR) &&
                           (mode_reg == POL_PSJF || mode_reg == POL_PPRI || !cur_valid_reg);
        stat.scan_last   = (scan_pos_reg + POS_W'(1) >= count_reg);
        stat.will_finish = (rem_reg[sel] <= BURST_BITS'(1));
        stat.order_done  = (rd_reg >= count_reg);
    end

    // Saturating arithmetic for the finishing process.
    logic [WAIT_W:0]  turn_full;
    logic [WAIT_W-1:0] turn_sat;
    logic [SUM_W:0]   sw_full, st_full;
    assign turn_full = {1'b0, wait_reg[victim_reg]} + (WAIT_W+1)'(burst_reg[victim_reg]);
    assign turn_sat  = turn_full[WAIT_W] ? '1 : turn_full[WAIT_W-1:0];
    assign sw_full   = {1'b0, sum_wait_reg} + (SUM_W+1)'(wait_reg[victim_reg]);
    assign st_full   = {1'b0, sum_turn_reg} + (SUM_W+1)'(turn_sat);

    // Current read pointer entry.
    logic [SLOT_W-1:0] rd_entry;
    assign rd_entry = order_reg[rd_reg[SLOT_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg    <= POL_FCFS;
            quantum_reg   <= QUANT_W'(4);
            valid_reg     <= '0;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            slice_reg     <= '0;
            sum_wait_reg  <= '0;
            sum_turn_reg  <= '0;
            done_reg      <= '0;
            fin_reg       <= 1'b0;
            idle_out_reg  <= 1'b1;
            run_out_reg   <= '0;
            fin_wait_reg  <= '0;
            fin_turn_reg  <= '0;
            rotating_reg  <= 1'b0;
        end else begin
            // Configuration writes.
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_POLICY) begin
                    policy_reg <= cfg_data[MODE_W-1:0];
                end else begin
                    quantum_reg <= cfg_data;
                end
            end

            // Arrival: load slot and append.
            if (cmd.arrive && arrive_ok) begin
                valid_reg[in_slot] <= 1'b1;
                rem_reg[in_slot]   <= in_burst;
                burst_reg[in_slot] <= in_burst;
                prio_reg[in_slot]  <= s_prio_level;
                wait_reg[in_slot]  <= '0;
                if (count_reg < POS_W'(MAX_PROCS)) begin
                    order_reg[count_reg[SLOT_W-1:0]] <= in_slot;
                    count_reg <= count_reg + POS_W'(1);
                end
            end

            // Tick start: effective mode, drop a stale current process.
            if (cmd.tick_start) begin
                mode_reg <= (policy_reg > POL_RR) ? POL_FCFS : policy_reg;
                if (cur_valid_reg && !valid_reg[cur_reg]) cur_valid_reg <= 1'b0;
                chosen_reg <= (cur_valid_reg && valid_reg[cur_reg]) ? cur_reg : order_reg[0];
            end

            // Idle tick.
            if (cmd.idle_tick) begin
                cur_valid_reg <= 1'b0;
                idle_out_reg  <= 1'b1;
                run_out_reg   <= '0;
                fin_reg       <= 1'b0;
                fin_wait_reg  <= '0;
                fin_turn_reg  <= '0;
            end

            // Round robin: remove expired process, then append at tail.
            if (cmd.rr_rotate) begin
                victim_reg   <= cur_reg;
                rotating_reg <= 1'b1;
                rd_reg       <= '0;
                wr_reg       <= '0;
            end

            // Selection scan over the ready order.
            if (cmd.scan_clear) begin
                best_pos_reg <= '0;
                scan_pos_reg <= POS_W'(1);
                chosen_reg   <= order_reg[0];
            end
            if (cmd.scan_step) begin
                if (scan_pos_reg < count_reg && better) begin
                    best_pos_reg <= scan_pos_reg;
                    chosen_reg   <= cand;
                end
                scan_pos_reg <= scan_pos_reg + POS_W'(1);
            end

            // One compaction step of the ready order. The expired process stays
            // current, so a lone process keeps its empty slice after rotation.
            if (cmd.order_step) begin
                if (rd_reg < count_reg) begin
                    if (rd_entry != victim_reg) begin
                        order_reg[wr_reg[SLOT_W-1:0]] <= rd_entry;
                        wr_reg <= wr_reg + POS_W'(1);
                    end
                    rd_reg <= rd_reg + POS_W'(1);
                end else if (rotating_reg) begin
                    order_reg[wr_reg[SLOT_W-1:0]] <= victim_reg;
                    chosen_reg   <= (wr_reg == '0) ? victim_reg : order_reg[0];
                    rotating_reg <= 1'b0;
                end else begin
                    count_reg <= wr_reg;
                end
            end

            // Commit the tick for the chosen process.
            if (cmd.commit) begin
                for (int i = 0; i < MAX_PROCS; i++) begin
                    if (valid_reg[i] && SLOT_W'(i) != sel && wait_reg[i] != '1) begin
                        wait_reg[i] <= wait_reg[i] + WAIT_W'(1);
                    end
                end
                rem_reg[sel] <= rem_reg[sel] - BURST_BITS'(1);
                if (!cur_valid_reg || cur_reg != sel) begin
                    slice_reg <= quant_eff - QUANT_W'(1);
                end else if (slice_reg != '0) begin
                    slice_reg <= slice_reg - QUANT_W'(1);
                end
                cur_valid_reg <= 1'b1;
                cur_reg       <= sel;
                run_out_reg   <= sel;
                idle_out_reg  <= 1'b0;
                fin_reg       <= 1'b0;
                fin_wait_reg  <= '0;
                fin_turn_reg  <= '0;
                victim_reg    <= sel;
                rd_reg        <= '0;
                wr_reg        <= '0;
            end

            // Completion bookkeeping.
            if (cmd.finish) begin
                fin_reg       <= 1'b1;
                fin_wait_reg  <= wait_reg[victim_reg];
                fin_turn_reg  <= turn_sat;
                sum_wait_reg  <= sw_full[SUM_W] ? '1 : sw_full[SUM_W-1:0];
                sum_turn_reg  <= st_full[SUM_W] ? '1 : st_full[SUM_W-1:0];
                if (done_reg != '1) done_reg <= done_reg + CNT_W'(1);
                valid_reg[victim_reg] <= 1'b0;
                cur_valid_reg <= 1'b0;
                slice_reg     <= '0;
            end
        end
    end

    assign m_running_id          = ID_W'(run_out_reg);
    assign m_cpu_idle            = idle_out_reg;
    assign m_finished            = fin_reg;
    assign m_finished_wait       = fin_wait_reg;
    assign m_finished_turnaround = fin_turn_reg;
    assign m_total_wait          = sum_wait_reg;
    assign m_total_turnaround    = sum_turn_reg;
    assign m_done_count          = done_reg;

endmodule

@@ design/multi_policy_process_scheduler.sv @@
// An arrive item yields no result. An idle tick passes through the start state only;
// a running tick passes through start, a policy scan over the ready processes or a round
// robin rotation when needed, then commit, plus compaction and finish for a completion.
// One item is in work at a time; the next is taken as the result is accepted.
// Reset (aresetn low, synchronous) empties all slots, clears sums and config defaults.
module multi_policy_process_scheduler
    import mpps_pkg::*;
#(
    parameter int MAX_PROCS  = MAX_PROCS_DEFAULT,
    parameter int BURST_BITS = BURST_BITS_DEFAULT
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [QUANT_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_command,
    input  logic [ID_W-1:0]      s_proc_id,
    input  logic [INBURST_W-1:0] s_burst_len,
    input  logic [PRIO_W-1:0]    s_prio_level,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ID_W-1:0]      m_running_id,
    output logic                 m_cpu_idle,
    output logic                 m_finished,
    output logic [WAIT_W-1:0]    m_finished_wait,
    output logic [WAIT_W-1:0]    m_finished_turnaround,
    output logic [SUM_W-1:0]     m_total_wait,
    output logic [SUM_W-1:0]     m_total_turnaround,
    output logic [CNT_W-1:0]     m_done_count
);

    mpps_cmd_t  cmd;
    mpps_stat_t stat;

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    mpps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mpps_dp #(
        .MAX_PROCS  (MAX_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_proc_id             (s_proc_id),
        .s_burst_len           (s_burst_len),
        .s_prio_level          (s_prio_level),
        .cmd                   (cmd),
        .stat                  (stat),
        .m_running_id          (m_running_id),
        .m_cpu_idle            (m_cpu_idle),
        .m_finished            (m_finished),
        .m_finished_wait       (m_finished_wait),
        .m_finished_turnaround (m_finished_turnaround),
        .m_total_wait          (m_total_wait),
        .m_total_turnaround    (m_total_turnaround),
        .m_done_count          (m_done_count)
    );

endmodule

@@ test/tb_multi_policy_process_scheduler.sv @@
module tb_multi_policy_process_scheduler;
    import mpps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // One input item of the scheduler.
    typedef struct packed {
        logic              command;
        logic [ID_W-1:0]   proc_id;
        logic [INBURST_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } sched_item_t;

    // One tick report.
    typedef struct packed {
        logic [ID_W-1:0]   running_id;
        logic              cpu_idle;
        logic              finished;
        logic [WAIT_W-1:0] fin_wait;
        logic [WAIT_W-1:0] fin_turn;
        logic [SUM_W-1:0]  sum_wait;
        logic [SUM_W-1:0]  sum_turn;
        logic [CNT_W-1:0]  done_count;
    } tick_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = REG_POLICY;
    logic [QUANT_W-1:0]   cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_ARRIVE;
    logic [ID_W-1:0]      s_proc_id = '0;
    logic [INBURST_W-1:0] s_burst_len = '0;
    logic [PRIO_W-1:0]    s_prio_level = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ID_W-1:0]      m_running_id;
    logic                 m_cpu_idle;
    logic                 m_finished;
    logic [WAIT_W-1:0]    m_finished_wait;
    logic [WAIT_W-1:0]    m_finished_turnaround;
    logic [SUM_W-1:0]     m_total_wait;
    logic [SUM_W-1:0]     m_total_turnaround;
    logic [CNT_W-1:0]     m_done_count;

    multi_policy_process_scheduler dut (.*);

    always #2 aclk = ~aclk;

    // Scheduler state mirrored for prediction.
    logic [MODE_W-1:0]  policy;
    logic [QUANT_W-1:0] quantum;
    logic               live [NPROC];
    logic [7:0]         remaining [NPROC];
    logic [7:0]         burst_of [NPROC];
    logic [PRIO_W-1:0]  prio_of [NPROC];
    logic [15:0]        waited [NPROC];
    int                 run_queue [$];
    int                 running;
    int                 slice;
    logic [SUM_W-1:0]   acc_wait;
    logic [SUM_W-1:0]   acc_turn;
    logic [CNT_W-1:0]   completions;

    sched_item_t  pending_items [$];
    tick_report_t expected_reports [$];
    int           error_count = 0;
    int           tick_count = 0;
    int           finish_count = 0;
    bit           calm = 1'b0;
    bit           hold_off = 1'b0;
    int           watchdog = 0;

    task automatic reset_model();
        policy = POL_FCFS;
        quantum = 8'd4;
        for (int i = 0; i < NPROC; i++) begin
            live[i] = 1'b0;
            remaining[i] = '0;
            burst_of[i] = '0;
            prio_of[i] = '0;
            waited[i] = '0;
        end
        run_queue.delete();
        running = NPROC;
        slice = 0;
        acc_wait = '0;
        acc_turn = '0;
        completions = '0;
    endtask

    function automatic void drop_from_queue(int id);
        for (int p = run_queue.size() - 1; p >= 0; p--)
            if (run_queue[p] == id) run_queue.delete(p);
    endfunction

    // Pick by policy, ties to the earliest entry in the run queue.
    function automatic int pick_by_policy(logic [MODE_W-1:0] mode);
        int best;
        int c;
        bit better;
        best = run_queue[0];
        for (int p = 1; p < run_queue.size(); p++) begin
            c = run_queue[p];
            better = 1'b0;
            if (mode == POL_NPSJF) better = burst_of[c] < burst_of[best];
            else if (mode == POL_PSJF) better = remaining[c] < remaining[best];
            else if (mode == POL_NPPRI || mode == POL_PPRI)
                better = prio_of[c] > prio_of[best];
            if (better) best = c;
        end
        return best;
    endfunction

    // Apply one accepted item and queue the tick report it produces.
    task automatic schedule_item(sched_item_t it);
        logic [MODE_W-1:0] mode;
        int q;
        int cur;
        tick_report_t r;
        logic [16:0] turn;
        logic [32:0] s;
        if (it.command == CMD_ARRIVE) begin
            if (!live[it.proc_id] && it.burst != 0) begin
                live[it.proc_id] = 1'b1;
                remaining[it.proc_id] = it.burst;
                burst_of[it.proc_id] = it.burst;
                prio_of[it.proc_id] = it.prio;
                waited[it.proc_id] = '0;
                if (run_queue.size() < NPROC) run_queue.push_back(int'(it.proc_id));
            end
            return;
        end
        mode = (policy > POL_RR) ? POL_FCFS : policy;
        q = (quantum == 0) ? 1 : int'(quantum);
        r = '0;
        if (running < NPROC && !live[running]) running = NPROC;
        if (run_queue.size() != 0) begin
            cur = running;
            if (mode == POL_RR) begin
                if (cur != NPROC && slice == 0) begin
                    drop_from_queue(cur);
                    run_queue.push_back(cur);
                    cur = NPROC;
                end
                if (cur == NPROC) cur = run_queue[0];
            end else if (mode == POL_PSJF || mode == POL_PPRI || cur == NPROC) begin
                cur = pick_by_policy(mode);
            end
            if (cur != running) slice = q;
            running = cur;
            for (int i = 0; i < NPROC; i++)
                if (live[i] && i != cur && waited[i] != 16'hFFFF) waited[i]++;
            if (remaining[cur] != 0) remaining[cur]--;
            if (slice != 0) slice--;
            if (remaining[cur] == 0) begin
                r.finished = 1'b1;
                r.fin_wait = waited[cur];
                turn = waited[cur] + burst_of[cur];
                r.fin_turn = turn[16] ? 16'hFFFF : turn[15:0];
                s = acc_wait + r.fin_wait;
                acc_wait = s[32] ? 32'hFFFFFFFF : s[31:0];
                s = acc_turn + r.fin_turn;
                acc_turn = s[32] ? 32'hFFFFFFFF : s[31:0];
                if (completions != 16'hFFFF) completions++;
                live[cur] = 1'b0;
                drop_from_queue(cur);
                running = NPROC;
                slice = 0;
            end
            r.running_id = cur[ID_W-1:0];
        end else begin
            running = NPROC;
            r.cpu_idle = 1'b1;
        end
        r.sum_wait = acc_wait;
        r.sum_turn = acc_turn;
        r.done_count = completions;
        expected_reports.push_back(r);
    endtask

    // Driver: offers queued items with random gaps.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                schedule_item({s_command, s_proc_id, s_burst_len, s_prio_level});
            end
            if (s_valid && !s_ready) begin
                // Keep offering the same item.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else begin
                    {s_command, s_proc_id, s_burst_len, s_prio_level} <=
                        pending_items.pop_front();
                    s_valid <= 1'b1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each report against the oldest expectation.
    int recv_gap = 0;
    always @(posedge aclk) begin
        tick_report_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report, running_id %0d", m_running_id);
                    error_count++;
                end else begin
                    e = expected_reports.pop_front();
                    tick_count++;
                    if (e.finished) finish_count++;
                    if (m_running_id !== e.running_id) begin
                        $error("running_id exp %0d got %0d", e.running_id, m_running_id);
                        error_count++;
                    end
                    if (m_cpu_idle !== e.cpu_idle) begin
                        $error("cpu_idle exp %0d got %0d", e.cpu_idle, m_cpu_idle);
                        error_count++;
                    end
                    if (m_finished !== e.finished) begin
                        $error("finished exp %0d got %0d", e.finished, m_finished);
                        error_count++;
                    end
                    if (m_finished_wait !== e.fin_wait) begin
                        $error("finished_wait exp %0d got %0d", e.fin_wait, m_finished_wait);
                        error_count++;
                    end
                    if (m_finished_turnaround !== e.fin_turn) begin
                        $error("finished_turnaround exp %0d got %0d", e.fin_turn,
                               m_finished_turnaround);
                        error_count++;
                    end
                    if (m_total_wait !== e.sum_wait) begin
                        $error("total_wait exp %0d got %0d", e.sum_wait, m_total_wait);
                        error_count++;
                    end
                    if (m_total_turnaround !== e.sum_turn) begin
                        $error("total_turnaround exp %0d got %0d", e.sum_turn,
                               m_total_turnaround);
                        error_count++;
                    end
                    if (m_done_count !== e.done_count) begin
                        $error("done_count exp %0d got %0d", e.done_count, m_done_count);
                        error_count++;
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted item or report.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || hold_off) begin
                watchdog <= 0;
            end else begin
                watchdog <= watchdog + 1;
                if (watchdog >= WATCHDOG_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    task automatic push_arrive(int id, int burst, int prio);
        sched_item_t it;
        it.command = CMD_ARRIVE;
        it.proc_id = ID_W'(id);
        it.burst = INBURST_W'(burst);
        it.prio = PRIO_W'(prio);
        pending_items.push_back(it);
    endtask

    task automatic push_tick();
        sched_item_t it;
        it.command = CMD_TICK;
        it.proc_id = ID_W'($urandom);
        it.burst = INBURST_W'($urandom);
        it.prio = PRIO_W'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Register writes happen only while the scheduler is idle.
    task automatic write_reg(logic idx, logic [QUANT_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_POLICY) policy = value[MODE_W-1:0];
        else quantum = value;
        @(posedge aclk);
    endtask

    // Mostly short bursts, a few long ones, a handful of ignored arrivals.
    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 2) == 0) begin
                push_arrive($urandom_range(0, 15),
                            ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                         : $urandom_range(1, 12),
                            $urandom_range(0, 15));
            end else begin
                push_tick();
            end
        end
    endtask

    initial begin
        int modes [8] = '{POL_RR, POL_FCFS, POL_NPSJF, POL_PSJF, POL_NPPRI, POL_PPRI,
                          3'd6, 3'd7};
        int quanta [8] = '{1, 255, 0, 2, 4, 3, 1, 7};
        reset_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, extremes of fields, duplicate and zero-burst arrivals.
        push_tick();
        push_arrive(0, 255, 0);
        push_arrive(15, 1, 15);
        push_arrive(15, 9, 3);
        push_arrive(7, 0, 8);
        push_arrive(5, 170, 10);
        push_arrive(10, 85, 5);
        repeat (12) push_tick();
        drain();
        write_reg(REG_POLICY, QUANT_W'(POL_PPRI));
        push_arrive(3, 2, 1);
        repeat (3) push_tick();
        drain();

        // Receiver holds off while the sender keeps going.
        hold_off = 1'b1;
        repeat (10) push_tick();
        repeat (300) @(posedge aclk);
        hold_off = 1'b0;
        drain();

        // Random phases across all policies and quantum extremes.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_POLICY, QUANT_W'(modes[ph]));
            write_reg(REG_QUANTUM, QUANT_W'(quanta[ph]));
            if (ph == 7) calm = 1'b1;
            random_phase(130);
            drain();
        end
        // Run off the remaining ticks so the start of the slot set drains.
        write_reg(REG_POLICY, QUANT_W'(POL_RR));
        repeat (120) push_tick();
        drain();

        $display("Covered %0d tick reports with %0d completions over eight policy settings.",
                 tick_count, finish_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
